/* sv/turntable_scan_point_converter_unit_assert.svh */
// ----------------------------------------------------------------------------
// Turntable scan point converter assertion macros
// Shorthand for the concurrent checks used in the converter RTL
// ----------------------------------------------------------------------------
`ifndef TURNTABLE_SCAN_POINT_CONVERTER_UNIT_ASSERT_SVH
`define TURNTABLE_SCAN_POINT_CONVERTER_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define TSP_ASSERT_SAME(label, clk_i, rstn_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TSP_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/tsp_pkg.sv */
// ----------------------------------------------------------------------------
// Turntable scan point converter package
// Shared types, codes, widths and trig table helpers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsp_pkg;

	// default sizes
	localparam int TRIG_ENTRIES_DEF = 128;
	localparam int SAMPLE_BITS_DEF  = 12;
	localparam int SAMPLE_MAX_BITS  = 16;

	// shared multiplier widths
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int WIDE_W  = MUL_P_W + 2;

	// port widths
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int OUT_TDATA_W = 104;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINE_SLOPE,
		CFG_LINE_OFFSET,
		CFG_CENTER_DISTANCE,
		CFG_MIN_VALID_SAMPLE,
		CFG_MM_PER_TURN,
		CFG_TOWER_STEPS_PER_TURN,
		CFG_MAX_TOWER_STEPS
	} cfg_idx_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIST,
		ST_ACC,
		ST_RAD,
		ST_MX,
		ST_MY,
		ST_FIN,
		ST_DONE
	} seq_state_t;

	// multiplier operand selection
	typedef enum logic [1:0] {
		OP_DIST,
		OP_Z,
		OP_X,
		OP_Y
	} op_sel_t;

	// sequencer to datapath control
	typedef struct packed {
		logic    idle;
		op_sel_t op;
		logic    ld_dist;
		logic    ld_z;
		logic    ld_rad;
		logic    ld_x;
		logic    ld_y;
		logic    load_out;
	} ctrl_t;

	// trig table constants, Q2.30
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam logic [63:0] SIN_DIV [7] = '{64'd210, 64'd156, 64'd110, 64'd72,
		64'd42, 64'd20, 64'd6};
	localparam logic [63:0] COS_DIV [7] = '{64'd182, 64'd132, 64'd90, 64'd56,
		64'd30, 64'd12, 64'd2};

	// truncating taylor series in horner form, Q2.30
	function automatic logic [63:0] horner_q30(input logic [63:0] x2, input logic odd_terms);
		logic [63:0] t;
		logic [63:0] sub;
		t = Q30_ONE;
		for (int k = 0; k < 7; k++) begin
			if (odd_terms)
				sub = ((x2 * t) >> 30) / SIN_DIV[k];
			else
				sub = ((x2 * t) >> 30) / COS_DIV[k];
			t = (sub >= Q30_ONE) ? 64'd0 : Q30_ONE - sub;
		end
		return t;
	endfunction

	// first quadrant sine or cosine in Q1.15, rounded half up and clamped
	function automatic logic signed [15:0] trig_q15(input logic [63:0] th,
		input logic want_sin);
		logic [63:0] x2;
		logic [63:0] v;
		logic [63:0] r;
		x2 = (th * th) >> 30;
		if (want_sin)
			v = (th * horner_q30(x2, 1'b1)) >> 30;
		else
			v = horner_q30(x2, 1'b0);
		r = (v + 64'd16384) >> 15;
		if (r > 64'd32767)
			r = 64'd32767;
		return 16'(r);
	endfunction

	// saturate a wide signed value to signed 32 bits
	function automatic logic signed [31:0] sat_s32(input logic signed [WIDE_W-1:0] v);
		logic signed [31:0] res;
		if (v > WIDE_W'(64'sd2147483647))
			res = 32'sh7FFF_FFFF;
		else if (v < WIDE_W'(-64'sd2147483648))
			res = 32'sh8000_0000;
		else
			res = v[31:0];
		return res;
	endfunction

endpackage

/* sv/tsp_trig_rom.sv */
// ----------------------------------------------------------------------------
// Turntable scan point converter trig table
// Q1.15 sine and cosine for each angle index, built at elaboration
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsp_trig_rom #(
	parameter int TRIG_ENTRIES = tsp_pkg::TRIG_ENTRIES_DEF,
	parameter int IDX_W        = $clog2(TRIG_ENTRIES)
) (
	input  logic [IDX_W-1:0]  idx,
	output logic signed [15:0] sin_val,
	output logic signed [15:0] cos_val
);

	logic signed [15:0] sin_tab [TRIG_ENTRIES];
	logic signed [15:0] cos_tab [TRIG_ENTRIES];

	// one entry per angle, quadrant folded from the first quadrant values
	for (genvar i = 0; i < TRIG_ENTRIES; i++) begin : g_entry
		localparam int unsigned QD = (4 * i) / TRIG_ENTRIES;
		localparam int unsigned RM = (4 * i) % TRIG_ENTRIES;
		localparam logic [63:0] TH = (tsp_pkg::PI_HALF_Q30 * 64'(RM)) / 64'(TRIG_ENTRIES);
		localparam logic signed [15:0] S15 = tsp_pkg::trig_q15(TH, 1'b1);
		localparam logic signed [15:0] C15 = tsp_pkg::trig_q15(TH, 1'b0);
		if (QD == 0) begin : g_q0
			assign sin_tab[i] = S15;
			assign cos_tab[i] = C15;
		end else if (QD == 1) begin : g_q1
			assign sin_tab[i] = C15;
			assign cos_tab[i] = -S15;
		end else if (QD == 2) begin : g_q2
			assign sin_tab[i] = -S15;
			assign cos_tab[i] = -C15;
		end else begin : g_q3
			assign sin_tab[i] = -C15;
			assign cos_tab[i] = S15;
		end
	end

	// table lookup at the current angle
	assign sin_val = sin_tab[idx];
	assign cos_val = cos_tab[idx];

endmodule

/* sv/tsp_mul.sv */
// ----------------------------------------------------------------------------
// Turntable scan point converter shared multiplier
// Operand select and one registered signed multiply used by every multiply step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsp_mul #(
	parameter int SAMPLE_BITS = tsp_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                 clk,
	input  tsp_pkg::op_sel_t                     op,
	input  logic signed [31:0]                   slope,
	input  logic [SAMPLE_BITS-1:0]               smp,
	input  logic [30:0]                          mm_turn,
	input  logic [15:0]                          turns,
	input  logic signed [31:0]                   rad,
	input  logic signed [15:0]                   sin_val,
	input  logic signed [15:0]                   cos_val,
	output logic signed [tsp_pkg::MUL_P_W-1:0]   prod_q
);

	logic signed [tsp_pkg::MUL_A_W-1:0] a;
	logic signed [tsp_pkg::MUL_B_W-1:0] b;

	// operand select
	always_comb begin
		case (op)
			tsp_pkg::OP_DIST: begin
				a = tsp_pkg::MUL_A_W'(slope);
				b = signed'(tsp_pkg::MUL_B_W'(smp));
			end
			tsp_pkg::OP_Z: begin
				a = signed'(tsp_pkg::MUL_A_W'(mm_turn));
				b = signed'(tsp_pkg::MUL_B_W'(turns));
			end
			tsp_pkg::OP_X: begin
				a = tsp_pkg::MUL_A_W'(rad);
				b = tsp_pkg::MUL_B_W'(sin_val);
			end
			default: begin
				a = tsp_pkg::MUL_A_W'(rad);
				b = tsp_pkg::MUL_B_W'(cos_val);
			end
		endcase
	end

	// registered product
	always_ff @(posedge clk) begin
		prod_q <= tsp_pkg::MUL_P_W'(a) * tsp_pkg::MUL_P_W'(b);
	end

endmodule

/* sv/tsp_seq.sv */
// ----------------------------------------------------------------------------
// Turntable scan point converter sequencer
// Steps the shared multiplier through distance, height, x and y per item that is not skipped
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsp_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic           skip,
	input  logic           out_free,
	output tsp_pkg::ctrl_t ctrl
);

	tsp_pkg::seq_state_t state_q;
	tsp_pkg::seq_state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and step controls
	always_comb begin
		state_nxt     = state_q;
		ctrl          = '0;
		ctrl.op       = tsp_pkg::OP_DIST;
		case (state_q)
			tsp_pkg::ST_IDLE: begin
				ctrl.idle = 1'b1;
				if (accept)
					state_nxt = skip ? tsp_pkg::ST_DONE : tsp_pkg::ST_DIST;
			end
			tsp_pkg::ST_DIST: begin
				ctrl.op   = tsp_pkg::OP_DIST;
				state_nxt = tsp_pkg::ST_ACC;
			end
			tsp_pkg::ST_ACC: begin
				ctrl.ld_dist = 1'b1;
				ctrl.op      = tsp_pkg::OP_Z;
				state_nxt    = tsp_pkg::ST_RAD;
			end
			tsp_pkg::ST_RAD: begin
				ctrl.ld_z   = 1'b1;
				ctrl.ld_rad = 1'b1;
				state_nxt   = tsp_pkg::ST_MX;
			end
			tsp_pkg::ST_MX: begin
				ctrl.op   = tsp_pkg::OP_X;
				state_nxt = tsp_pkg::ST_MY;
			end
			tsp_pkg::ST_MY: begin
				ctrl.ld_x = 1'b1;
				ctrl.op   = tsp_pkg::OP_Y;
				state_nxt = tsp_pkg::ST_FIN;
			end
			tsp_pkg::ST_FIN: begin
				ctrl.ld_y = 1'b1;
				state_nxt = tsp_pkg::ST_DONE;
			end
			tsp_pkg::ST_DONE: begin
				if (out_free) begin
					ctrl.load_out = 1'b1;
					state_nxt     = tsp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = tsp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* sv/turntable_scan_point_converter_unit.sv */
// A sample above threshold is accepted in the idle slot, then steps through DIST, ACC, RAD,
// MX, MY, FIN and DONE, seven steps around four multiplies; no new item is taken meanwhile.
// Reset commands and samples at or below threshold skip from idle straight to DONE.
// The output register holds a result while the next item is taken in.
// arst_n clears counters, configuration registers and all handshake state.
// ----------------------------------------------------------------------------
// Turntable scan point converter
// Sensor sample to x, y, z point with turntable angle and tower counters
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "turntable_scan_point_converter_unit_assert.svh"

module turntable_scan_point_converter_unit #(
	parameter int TRIG_ENTRIES = tsp_pkg::TRIG_ENTRIES_DEF,
	parameter int SAMPLE_BITS  = tsp_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input items
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // sample
	input  logic                                s_tuser,  // command
	// result items
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// point_x, point_y, point_z, tower_advance, scan_done
	output logic [tsp_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                m_tuser,  // point_valid
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tsp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tsp_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int IDX_W = $clog2(TRIG_ENTRIES);

	// configuration registers
	logic signed [31:0] slope_q;
	logic signed [31:0] offset_q;
	logic [30:0]        center_q;
	logic [11:0]        min_q;
	logic [30:0]        mm_turn_q;
	logic [15:0]        tsteps_q;
	logic [31:0]        max_steps_q;

	// scan counters
	logic [IDX_W-1:0]   angle_q;
	logic [15:0]        turn_q;
	logic [31:0]        total_q;

	// item and working registers
	logic                       cmd_q;
	logic                       pv_q;
	logic [SAMPLE_BITS-1:0]     smp_q;
	logic signed [31:0]         dist_q;
	logic signed [31:0]         rad_q;
	logic signed [31:0]         x_q;
	logic signed [31:0]         y_q;
	logic [30:0]                z_q;

	// result register
	logic                       m_tvalid_q;
	logic                       pv_out_q;
	logic signed [31:0]         x_out_q;
	logic signed [31:0]         y_out_q;
	logic [30:0]                z_out_q;
	logic                       adv_out_q;
	logic                       done_out_q;

	tsp_pkg::ctrl_t                       ctrl;
	logic                                 accept;
	logic                                 smp_ok;
	logic [SAMPLE_BITS-1:0]               smp_in;
	logic signed [15:0]                   sin_val;
	logic signed [15:0]                   cos_val;
	logic signed [tsp_pkg::MUL_P_W-1:0]   prod_q;
	logic signed [tsp_pkg::WIDE_W-1:0]    dist_sum;
	logic signed [tsp_pkg::WIDE_W-1:0]    rad_sum;
	logic signed [tsp_pkg::WIDE_W-1:0]    trig_sum;
	logic signed [tsp_pkg::WIDE_W-1:0]    trig_shift;
	logic [32:0]                          total_sum;
	logic                                 wrap;
	logic [IDX_W-1:0]                     angle_nxt;
	logic [15:0]                          turn_nxt;
	logic [31:0]                          total_nxt;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = ctrl.idle;
	assign cfg_ready = 1'b1;
	assign smp_in    = s_tdata[SAMPLE_BITS-1:0];
	assign smp_ok    = tsp_pkg::SAMPLE_MAX_BITS'(smp_in) > tsp_pkg::SAMPLE_MAX_BITS'(min_q);

	// sequencer
	tsp_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.skip     (s_tuser || !smp_ok),
		.out_free (!m_tvalid_q || m_tready),
		.ctrl     (ctrl)
	);

	// sine and cosine at the current angle
	tsp_trig_rom #(
		.TRIG_ENTRIES (TRIG_ENTRIES),
		.IDX_W        (IDX_W)
	) u_rom (
		.idx     (angle_q),
		.sin_val (sin_val),
		.cos_val (cos_val)
	);

	// shared multiplier
	tsp_mul #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mul (
		.clk     (clk),
		.op      (ctrl.op),
		.slope   (slope_q),
		.smp     (smp_q),
		.mm_turn (mm_turn_q),
		.turns   (turn_q),
		.rad     (rad_q),
		.sin_val (sin_val),
		.cos_val (cos_val),
		.prod_q  (prod_q)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slope_q     <= '0;
			offset_q    <= '0;
			center_q    <= '0;
			min_q       <= '0;
			mm_turn_q   <= '0;
			tsteps_q    <= '0;
			max_steps_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (tsp_pkg::cfg_idx_t'(cfg_index))
				tsp_pkg::CFG_LINE_SLOPE:           slope_q     <= cfg_data;
				tsp_pkg::CFG_LINE_OFFSET:          offset_q    <= cfg_data;
				tsp_pkg::CFG_CENTER_DISTANCE:      center_q    <= cfg_data[30:0];
				tsp_pkg::CFG_MIN_VALID_SAMPLE:     min_q       <= cfg_data[11:0];
				tsp_pkg::CFG_MM_PER_TURN:          mm_turn_q   <= cfg_data[30:0];
				tsp_pkg::CFG_TOWER_STEPS_PER_TURN: tsteps_q    <= cfg_data[15:0];
				tsp_pkg::CFG_MAX_TOWER_STEPS:      max_steps_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// post-multiply arithmetic
	assign dist_sum   = tsp_pkg::WIDE_W'(prod_q) + tsp_pkg::WIDE_W'(offset_q);
	assign rad_sum    = signed'(tsp_pkg::WIDE_W'(center_q)) - tsp_pkg::WIDE_W'(dist_q);
	assign trig_sum   = tsp_pkg::WIDE_W'(prod_q) + tsp_pkg::WIDE_W'(17'sd16384);
	assign trig_shift = trig_sum >>> 15;

	// item capture and working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= s_tuser;
			pv_q  <= !s_tuser && smp_ok;
			smp_q <= smp_in;
		end
		if (ctrl.ld_dist)
			dist_q <= tsp_pkg::sat_s32(dist_sum);
		if (ctrl.ld_rad)
			rad_q <= tsp_pkg::sat_s32(rad_sum);
		if (ctrl.ld_z)
			z_q <= (prod_q > tsp_pkg::MUL_P_W'(64'sd2147483647)) ? 31'h7FFF_FFFF : prod_q[30:0];
		if (ctrl.ld_x)
			x_q <= tsp_pkg::sat_s32(trig_shift);
		if (ctrl.ld_y)
			y_q <= tsp_pkg::sat_s32(trig_shift);
	end

	// counter step
	assign wrap      = (angle_q == IDX_W'(TRIG_ENTRIES - 1));
	assign total_sum = {1'b0, total_q} + 33'(tsteps_q);
	always_comb begin
		angle_nxt = angle_q;
		turn_nxt  = turn_q;
		total_nxt = total_q;
		if (cmd_q) begin
			angle_nxt = '0;
			turn_nxt  = '0;
			total_nxt = '0;
		end else if (wrap) begin
			angle_nxt = '0;
			turn_nxt  = (turn_q == 16'hFFFF) ? turn_q : turn_q + 16'd1;
			total_nxt = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
		end else begin
			angle_nxt = angle_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			turn_q  <= '0;
			total_q <= '0;
		end else if (ctrl.load_out) begin
			angle_q <= angle_nxt;
			turn_q  <= turn_nxt;
			total_q <= total_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			pv_out_q   <= pv_q;
			x_out_q    <= pv_q ? x_q : '0;
			y_out_q    <= pv_q ? y_q : '0;
			z_out_q    <= pv_q ? z_q : '0;
			adv_out_q  <= !cmd_q && wrap;
			done_out_q <= total_nxt >= max_steps_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = pv_out_q;
	assign m_tdata  = {7'd0, done_out_q, adv_out_q, z_out_q, y_out_q, x_out_q};

	// checks
	`TSP_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, !s_tready,
		"input accepted while an item is still in work")
	`TSP_ASSERT_SAME(a_angle_in_range, clk, arst_n, 1'b1,
		32'(angle_q) < 32'(TRIG_ENTRIES), "angle index beyond table")
	`TSP_ASSERT_SAME(a_result_from_load, clk, arst_n, $rose(m_tvalid_q), $past(ctrl.load_out),
		"result valid without a load")
	`TSP_ASSERT_NEXT(a_wrap_clears_angle, clk, arst_n, ctrl.load_out && (cmd_q || wrap),
		angle_q == '0, "angle not cleared on wrap or reset command")

endmodule

/* sim/tsp_point_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turntable scan point checker
// Watches the sample, point and register channels of the converter, works out
// every point from its own copy of the counters and registers, and compares
// each result item against the oldest point still owed.
// ----------------------------------------------------------------------------

module tsp_point_checker #(
	parameter int ANGLE_STEPS = tsp_pkg::TRIG_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [15:0]                       s_tdata,  // sample
	input  logic                              s_tuser,  // command
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	// point_x, point_y, point_z, tower_advance, scan_done
	input  logic [tsp_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  logic                              m_tuser,  // point_valid
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [tsp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tsp_pkg::CFG_DATA_W-1:0]    cfg_data,
	output int                                fail_count,
	output int                                pending,
	output int                                checked,
	output int                                points_seen
);

	localparam longint unsigned ONE_Q30       = 64'd1073741824;
	localparam longint unsigned QUARTER_PI_X2 = 64'd1686629713;

	typedef struct packed {
		logic               valid;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [30:0]        z;
		logic               advance;
		logic               done;
	} scan_point_t;

	// register copies
	logic signed [31:0] slope_q16;
	logic signed [31:0] offset_q16;
	logic [30:0]        center_q16;
	logic [11:0]        threshold;
	logic [30:0]        lift_per_turn;
	logic [15:0]        steps_per_turn;
	logic [31:0]        steps_limit;

	// turntable and tower counters
	logic [7:0]  angle;
	logic [15:0] turns;
	logic [31:0] tower_total;

	scan_point_t owed_points[$];

	function automatic longint clamp_s32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// truncating taylor series, Q2.30, terms from top_n down to 2 or 1 in steps of 2
	function automatic longint unsigned series_q30(input longint unsigned x2, input int top_n);
		longint unsigned acc;
		longint unsigned sub;
		acc = ONE_Q30;
		for (int n = top_n; n >= 1; n -= 2) begin
			sub = ((x2 * acc) >> 30) / longint'(n * (n + 1));
			acc = (sub >= ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
		end
		return acc;
	endfunction

	function automatic int to_q15(input longint unsigned v);
		longint unsigned r;
		r = (v + 64'd16384) >> 15;
		return (r > 64'd32767) ? 32767 : int'(r);
	endfunction

	// sine and cosine in Q1.15 at one angle step, folded from the first quadrant
	function automatic void rom_sin_cos(input int idx, output int sn, output int cs);
		int quad;
		int rem;
		longint unsigned th;
		longint unsigned x2;
		int s15;
		int c15;
		quad = (4 * (idx % ANGLE_STEPS)) / ANGLE_STEPS;
		rem  = (4 * (idx % ANGLE_STEPS)) % ANGLE_STEPS;
		th   = (QUARTER_PI_X2 * longint'(rem)) / longint'(ANGLE_STEPS);
		x2   = (th * th) >> 30;
		s15  = to_q15((th * series_q30(x2, 14)) >> 30);
		c15  = to_q15(series_q30(x2, 13));
		case (quad & 3)
			0: begin
				sn = s15;  cs = c15;
			end
			1: begin
				sn = c15;  cs = -s15;
			end
			2: begin
				sn = -s15; cs = -c15;
			end
			default: begin
				sn = -c15; cs = s15;
			end
		endcase
	endfunction

	// one item: point from the current angle, then advance the counters, or clear them on a clear command
	function automatic scan_point_t predict_point(input logic clear, input logic [11:0] smp);
		scan_point_t p;
		longint dist_mm;
		longint rad;
		longint lift;
		longint unsigned sum;
		int sn;
		int cs;
		p = '0;
		if (clear) begin
			angle       = '0;
			turns       = '0;
			tower_total = '0;
		end else begin
			if (smp > threshold) begin
				dist_mm = clamp_s32(longint'(smp) * longint'(slope_q16) + longint'(offset_q16));
				rad  = clamp_s32(longint'(center_q16) - dist_mm);
				rom_sin_cos(int'(angle), sn, cs);
				p.x  = 32'(clamp_s32((rad * longint'(sn) + 64'sd16384) >>> 15));
				p.y  = 32'(clamp_s32((rad * longint'(cs) + 64'sd16384) >>> 15));
				lift = longint'(turns) * longint'(lift_per_turn);
				p.z  = (lift > 64'sd2147483647) ? 31'h7FFF_FFFF : 31'(lift);
				p.valid = 1'b1;
			end
			angle = angle + 8'd1;
			if (int'(angle) >= ANGLE_STEPS) begin
				angle = '0;
				sum = longint'(tower_total) + longint'(steps_per_turn);
				tower_total = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(sum);
				if (turns != 16'hFFFF)
					turns = turns + 16'd1;
				p.advance = 1'b1;
			end
		end
		p.done = (tower_total >= steps_limit);
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		scan_point_t got;
		scan_point_t want;
		if (!arst_n) begin
			slope_q16      <= '0;
			offset_q16     <= '0;
			center_q16     <= '0;
			threshold      <= '0;
			lift_per_turn  <= '0;
			steps_per_turn <= '0;
			steps_limit    <= '0;
			angle          = '0;
			turns          = '0;
			tower_total    = '0;
			owed_points.delete();
			fail_count  <= 0;
			pending     <= 0;
			checked     <= 0;
			points_seen <= 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (tsp_pkg::cfg_idx_t'(cfg_index))
					tsp_pkg::CFG_LINE_SLOPE:           slope_q16      <= cfg_data;
					tsp_pkg::CFG_LINE_OFFSET:          offset_q16     <= cfg_data;
					tsp_pkg::CFG_CENTER_DISTANCE:      center_q16     <= cfg_data[30:0];
					tsp_pkg::CFG_MIN_VALID_SAMPLE:     threshold      <= cfg_data[11:0];
					tsp_pkg::CFG_MM_PER_TURN:          lift_per_turn  <= cfg_data[30:0];
					tsp_pkg::CFG_TOWER_STEPS_PER_TURN: steps_per_turn <= cfg_data[15:0];
					tsp_pkg::CFG_MAX_TOWER_STEPS:      steps_limit    <= cfg_data;
					default: ;
				endcase
			end
			// result item against the oldest owed point
			if (m_tvalid && m_tready) begin
				got.valid   = m_tuser;
				got.x       = m_tdata[31:0];
				got.y       = m_tdata[63:32];
				got.z       = m_tdata[94:64];
				got.advance = m_tdata[95];
				got.done    = m_tdata[96];
				if (owed_points.size() == 0) begin
					$error("result item arrived with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					want = owed_points.pop_front();
					if (got != want)
						fail_count <= fail_count + 1;
					if (got.valid != want.valid)
						$error("point_valid: expected %0d, got %0d", want.valid, got.valid);
					if (got.x != want.x)
						$error("point_x: expected %0d, got %0d", want.x, got.x);
					if (got.y != want.y)
						$error("point_y: expected %0d, got %0d", want.y, got.y);
					if (got.z != want.z)
						$error("point_z: expected %0d, got %0d", want.z, got.z);
					if (got.advance != want.advance)
						$error("tower_advance: expected %0d, got %0d", want.advance,
							got.advance);
					if (got.done != want.done)
						$error("scan_done: expected %0d, got %0d", want.done, got.done);
				end
				checked <= checked + 1;
				if (got.valid)
					points_seen <= points_seen + 1;
			end
			// accepted sample or clear command
			if (s_tvalid && s_tready)
				owed_points.push_back(predict_point(s_tuser, s_tdata[11:0]));
			pending <= owed_points.size();
		end
	end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turntable scan point converter testbench
// Programs a series of calibration and tower settings, from realistic values
// to both extremes, sends a directed set of samples and clear commands and
// then bursts of random ones under random back-pressure; the checker compares
// every point item with its own prediction.
// ----------------------------------------------------------------------------

module tb_top;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;
	localparam int   IDLE_LIMIT = 3000;
	localparam int   LONG_HOLD  = 500;
	localparam int   SETTLE     = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                                s_tvalid = 1'b0;
	logic                                s_tready;
	logic [15:0]                         s_tdata = '0;
	logic                                s_tuser = 1'b0;
	logic                                m_tvalid;
	logic                                m_tready = 1'b0;
	logic [tsp_pkg::OUT_TDATA_W-1:0]     m_tdata;
	logic                                m_tuser;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [tsp_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
	logic [tsp_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

	int fail_count;
	int pending;
	int checked;
	int points_seen;

	int  burst_left = 0;
	int  items_sent = 0;
	int  clears_sent = 0;
	int  settings_done = 0;
	int  idle_cycles = 0;
	bit  hold_req = 1'b0;
	bit  hold_done = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	turntable_scan_point_converter_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tsp_point_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.pending     (pending),
		.checked     (checked),
		.points_seen (points_seen)
	);

	// watchdog on cycles with no handshake on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// point receiver: random stall patterns, one long hold when asked
	initial begin : receiver
		int span;
		int mode;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(5, 60);
			repeat (span) begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 1) != 0);
					default: m_tready <= ($urandom_range(0, 4) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// one item in bursts with random gaps between them
	task automatic send_item(input logic cmd, input logic [11:0] smp);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 20);
			burst_left = $urandom_range(1, 40);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0000, smp};
		s_tuser  <= cmd;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		if (cmd == CMD_CLEAR)
			clears_sent++;
	endtask

	// wait until every owed point has come and the block has settled
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input tsp_pkg::cfg_idx_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic program_setting(input logic [31:0] slope, input logic [31:0] offset,
		input logic [31:0] center, input logic [31:0] thresh, input logic [31:0] lift,
		input logic [31:0] steps, input logic [31:0] limit);
		write_reg(tsp_pkg::CFG_LINE_SLOPE, slope);
		write_reg(tsp_pkg::CFG_LINE_OFFSET, offset);
		write_reg(tsp_pkg::CFG_CENTER_DISTANCE, center);
		write_reg(tsp_pkg::CFG_MIN_VALID_SAMPLE, thresh);
		write_reg(tsp_pkg::CFG_MM_PER_TURN, lift);
		write_reg(tsp_pkg::CFG_TOWER_STEPS_PER_TURN, steps);
		write_reg(tsp_pkg::CFG_MAX_TOWER_STEPS, limit);
		cfg_valid <= 1'b0;
		settings_done++;
	endtask

	// random samples and clear commands, mostly samples over the full range, some clustered around the threshold
	task automatic random_items(input int count, input logic [11:0] thresh);
		logic cmd;
		logic [11:0] smp;
		int pick;
		for (int i = 0; i < count; i++) begin
			cmd  = ($urandom_range(0, 99) < 2) ? CMD_CLEAR : CMD_SAMPLE;
			pick = $urandom_range(0, 9);
			if (pick < 6)
				smp = 12'($urandom_range(0, 4095));
			else if (pick < 8)
				smp = 12'(int'(thresh) + $urandom_range(0, 6) - 3);
			else if (pick < 9)
				smp = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
			else
				smp = 12'($urandom_range(0, int'(thresh)));
			send_item(cmd, smp);
		end
	endtask

	initial begin : stimulus
		logic [11:0] directed_smp [12];
		logic [31:0] slope;
		logic [31:0] steps;
		logic [11:0] thresh;
		directed_smp = '{12'd0, 12'd200, 12'd201, 12'hFFF, 12'h800, 12'h555,
			12'hAAA, 12'd1, 12'h7FF, 12'hC00, 12'd199, 12'hF0F};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// realistic calibration, threshold 200, scan ends after three turns
		program_setting(32'h0000_4000, 32'h000A_0000, 32'h0096_0000, 32'd200,
			32'h0002_8000, 32'd400, 32'd1200);
		foreach (directed_smp[k])
			send_item(CMD_SAMPLE, directed_smp[k]);
		send_item(CMD_CLEAR, 12'hFFF);
		send_item(CMD_SAMPLE, 12'hFFF);
		send_item(CMD_CLEAR, 12'h000);
		send_item(CMD_SAMPLE, 12'd300);
		random_items(300, 12'd200);
		drain();

		// all registers but the threshold at their highest values, threshold at zero, long receiver hold part way
		program_setting(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0,
			32'h7FFF_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF);
		random_items(20, 12'd0);
		hold_req = 1'b1;
		random_items(230, 12'd0);
		drain();

		// most negative calibration, zero distances and limits
		program_setting(32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		random_items(250, 12'd0);
		drain();

		// threshold at the top, no points at all
		program_setting(32'h0001_0000, 32'd0, 32'h0100_0000, 32'd4095, 32'h0001_0000,
			32'd1, 32'd2);
		random_items(150, 12'hFFF);
		drain();

		// random settings
		repeat (4) begin
			slope  = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0002_0000);
			steps  = $urandom_range(0, 65535);
			thresh = 12'($urandom_range(0, 1500));
			program_setting(slope, $urandom, $urandom & 32'h7FFF_FFFF, 32'(thresh),
				$urandom & 32'h7FFF_FFFF, steps,
				$urandom_range(0, 1) ? $urandom : steps * $urandom_range(0, 3));
			random_items(220, thresh);
			drain();
		end

		$display("Sent %0d items (%0d counter clears) over %0d register settings;",
			items_sent, clears_sent, settings_done);
		$display("checked %0d result items, %0d of them carrying a point.",
			checked, points_seen);
		if (fail_count == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* sim.f */
+incdir+sv
sv/tsp_pkg.sv
sv/tsp_trig_rom.sv
sv/tsp_mul.sv
sv/tsp_seq.sv
sv/turntable_scan_point_converter_unit.sv
sim/tsp_point_checker.sv
sim/tb_top.sv
